// File: src/via_pkg.sv
// Types, register map and constants shared by the timer register block.
package via_pkg;

  // Number of key matrix rows held on chip
  localparam int unsigned KeyRowCountDef = 9;

  // Operation carried by each request
  typedef enum logic [1:0] {
    ActRead    = 2'd0,
    ActWrite   = 2'd1,
    ActTick    = 2'd2,
    ActKeyLoad = 2'd3
  } via_action_e;

  // Register map
  localparam logic [3:0] RegPortB    = 4'd0;
  localparam logic [3:0] RegRowSel   = 4'd1;
  localparam logic [3:0] RegT1CntLo  = 4'd4;
  localparam logic [3:0] RegT1CntHi  = 4'd5;
  localparam logic [3:0] RegT1LatLo  = 4'd6;
  localparam logic [3:0] RegT1LatHi  = 4'd7;
  localparam logic [3:0] RegT2CntLo  = 4'd8;
  localparam logic [3:0] RegT2CntHi  = 4'd9;
  localparam logic [3:0] RegAcr      = 4'd11;
  localparam logic [3:0] RegIfr      = 4'd13;

  localparam int unsigned NumRegs    = 16;

  // Bit masks
  localparam logic [7:0] MaskPortHi2 = 8'hC0;
  localparam logic [7:0] MaskPortLo6 = 8'h3F;
  localparam logic [7:0] MaskIfrT1   = 8'h40;
  localparam logic [7:0] MaskIfrT2   = 8'h20;
  localparam logic [7:0] MaskNotT1   = 8'hBF;
  localparam logic [7:0] MaskNotT2   = 8'hDF;
  localparam logic [7:0] MaskAcrPb7  = 8'h80;
  localparam logic [1:0] AcrSquare   = 2'b11;
  localparam logic [7:0] KeyRowIdle  = 8'hFF;

  typedef struct packed {
    via_action_e action;
    logic [3:0]  reg_addr;
    logic [7:0]  write_data;
    logic [7:0]  cycle_count;
    logic [3:0]  key_row;
  } via_req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        tone_update;
    logic [15:0] tone_period;
    logic        pb7_level;
  } via_rsp_t;

endpackage

// File: src/via_timer_register_block.sv
// Top level: request register, processing core and response register.
//
// Usage
//   Requests arrive on in_valid_i / in_ready_o with the payload in_req_i:
//   a register read, a register write, a timer tick or a key row load.
//   Every request yields exactly one response on out_valid_o / out_ready_i
//   (out_rsp_o): read data, a tone update with its period, and PB7.
//   A request passes through the request register and then the response
//   register before its response is valid.
//   Throughput: one request per cycle while responses are taken; the state
//   change of each request is committed as it moves into the response
//   register, so the next request sees it with no bubble.
//   Reset clears all sixteen registers, sets every key row to all ones
//   (no key pressed) and empties both pipeline registers.
//   When the receiver stalls, the response holds; the request register
//   fills behind it and in_ready_o drops until the response is taken.
module via_timer_register_block #(
  parameter int unsigned KEY_ROW_COUNT = via_pkg::KeyRowCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  via_pkg::via_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output via_pkg::via_rsp_t  out_rsp_o
);

  logic              req_valid_q;
  via_pkg::via_req_t req_q;
  logic              rsp_valid_q;
  via_pkg::via_rsp_t rsp_q;
  via_pkg::via_rsp_t rsp_d;
  logic              advance;

  // Move the held request on when the response slot is free or draining
  assign advance    = req_valid_q && (!rsp_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || advance;

  via_core #(
    .KEY_ROW_COUNT(KEY_ROW_COUNT)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(advance),
    .req_i (req_q),
    .rsp_o (rsp_d)
  );

  // Request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// File: src/via_core.sv
// Register file, key matrix and the single-pass request logic.
module via_core #(
  parameter int unsigned KEY_ROW_COUNT = via_pkg::KeyRowCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  via_pkg::via_req_t  req_i,
  output via_pkg::via_rsp_t  rsp_o
);

  localparam int unsigned RowIdxW = (KEY_ROW_COUNT > 1) ? $clog2(KEY_ROW_COUNT) : 1;

  logic [7:0] regs_q [via_pkg::NumRegs];
  logic [7:0] regs_d [via_pkg::NumRegs];
  logic [7:0] keys_q [KEY_ROW_COUNT];
  logic [7:0] keys_d [KEY_ROW_COUNT];

  logic [3:0]  sel_row;
  logic [7:0]  sel_keys;
  logic [15:0] t1_cnt;
  logic [15:0] t1_lat;
  logic [15:0] t1_next;
  logic [15:0] t2_cnt;
  logic [15:0] t2_next;

  // Look up the selected key row; rows beyond the matrix read idle
  assign sel_row = regs_q[via_pkg::RegRowSel][3:0];
  always_comb begin
    if ({1'b0, sel_row} < 5'(KEY_ROW_COUNT)) begin
      sel_keys = keys_q[sel_row[RowIdxW-1:0]];
    end else begin
      sel_keys = via_pkg::KeyRowIdle;
    end
  end

  assign t1_cnt = {regs_q[via_pkg::RegT1CntHi], regs_q[via_pkg::RegT1CntLo]};
  assign t1_lat = {regs_q[via_pkg::RegT1LatHi], regs_q[via_pkg::RegT1LatLo]};
  assign t2_cnt = {regs_q[via_pkg::RegT2CntHi], regs_q[via_pkg::RegT2CntLo]};

  // Work out the next state and the response for one request
  always_comb begin
    regs_d  = regs_q;
    keys_d  = keys_q;
    rsp_o   = '0;
    t1_next = t1_cnt;
    t2_next = t2_cnt;
    case (req_i.action)
      via_pkg::ActRead: begin
        case (req_i.reg_addr)
          via_pkg::RegPortB: begin
            rsp_o.read_data = sel_keys | (regs_q[via_pkg::RegPortB] & via_pkg::MaskPortHi2);
          end
          via_pkg::RegT1CntLo: begin
            regs_d[via_pkg::RegIfr] = regs_q[via_pkg::RegIfr] & via_pkg::MaskNotT1;
            rsp_o.read_data = regs_q[via_pkg::RegT1CntLo];
          end
          via_pkg::RegT2CntLo: begin
            regs_d[via_pkg::RegIfr] = regs_q[via_pkg::RegIfr] & via_pkg::MaskNotT2;
            rsp_o.read_data = regs_q[via_pkg::RegT2CntLo];
          end
          default: begin
            rsp_o.read_data = regs_q[req_i.reg_addr];
          end
        endcase
      end
      via_pkg::ActWrite: begin
        case (req_i.reg_addr)
          via_pkg::RegT1CntLo, via_pkg::RegT1LatLo: begin
            regs_d[via_pkg::RegT1CntLo] = req_i.write_data;
            regs_d[via_pkg::RegT1LatLo] = req_i.write_data;
          end
          via_pkg::RegT1CntHi, via_pkg::RegT1LatHi: begin
            regs_d[via_pkg::RegT1CntHi] = req_i.write_data;
            regs_d[via_pkg::RegT1LatHi] = req_i.write_data;
            regs_d[via_pkg::RegIfr] = regs_q[via_pkg::RegIfr] & via_pkg::MaskNotT1;
            if (regs_q[via_pkg::RegAcr][7:6] == via_pkg::AcrSquare) begin
              rsp_o.tone_update = 1'b1;
              rsp_o.tone_period = {req_i.write_data, regs_q[via_pkg::RegT1LatLo]};
            end
          end
          via_pkg::RegT2CntHi: begin
            regs_d[via_pkg::RegT2CntHi] = req_i.write_data;
            regs_d[via_pkg::RegIfr] = regs_q[via_pkg::RegIfr] & via_pkg::MaskNotT2;
          end
          via_pkg::RegAcr: begin
            if (req_i.write_data[7:6] != via_pkg::AcrSquare) begin
              rsp_o.tone_update = 1'b1;
            end
            regs_d[via_pkg::RegAcr] = req_i.write_data;
          end
          default: begin
            regs_d[req_i.reg_addr] = req_i.write_data;
          end
        endcase
      end
      via_pkg::ActTick: begin
        if (t1_cnt > {8'd0, req_i.cycle_count}) begin
          t1_next = t1_cnt - {8'd0, req_i.cycle_count};
        end else begin
          // Underflow: reload from the latch, toggle PB7 when ACR bit 7 is set
          t1_next = t1_lat - {8'd0, req_i.cycle_count};
          if ((regs_q[via_pkg::RegAcr] & via_pkg::MaskAcrPb7) != 8'd0) begin
            if (!regs_q[via_pkg::RegPortB][7]) begin
              regs_d[via_pkg::RegPortB] = regs_q[via_pkg::RegPortB] | via_pkg::MaskPortHi2;
            end else begin
              regs_d[via_pkg::RegPortB] = regs_q[via_pkg::RegPortB] & via_pkg::MaskPortLo6;
              if (t2_cnt != 16'd0) begin
                t2_next = t2_cnt - 16'd1;
                if (t2_next == 16'd0) begin
                  regs_d[via_pkg::RegIfr] = regs_q[via_pkg::RegIfr] | via_pkg::MaskIfrT2;
                end
              end
              regs_d[via_pkg::RegT2CntLo] = t2_next[7:0];
              regs_d[via_pkg::RegT2CntHi] = t2_next[15:8];
            end
          end
          regs_d[via_pkg::RegIfr] = regs_d[via_pkg::RegIfr] | via_pkg::MaskIfrT1;
        end
        regs_d[via_pkg::RegT1CntLo] = t1_next[7:0];
        regs_d[via_pkg::RegT1CntHi] = t1_next[15:8];
      end
      via_pkg::ActKeyLoad: begin
        if ({1'b0, req_i.key_row} < 5'(KEY_ROW_COUNT)) begin
          keys_d[req_i.key_row[RowIdxW-1:0]] = req_i.write_data;
        end
      end
      default: begin
        regs_d = regs_q;
      end
    endcase
    rsp_o.pb7_level = regs_d[via_pkg::RegPortB][7];
  end

  // Commit state when a request goes through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < via_pkg::NumRegs; i++) begin
        regs_q[i] <= '0;
      end
      for (int i = 0; i < KEY_ROW_COUNT; i++) begin
        keys_q[i] <= via_pkg::KeyRowIdle;
      end
    end else if (fire_i) begin
      regs_q <= regs_d;
      keys_q <= keys_d;
    end
  end

endmodule

// File: src/via_chk.sv
// Port-level checker for the timer register block, bound to the top level.
module via_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input via_pkg::via_rsp_t out_rsp_o
);

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  // Refuse requests only behind a stalled response
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request refused without a stalled response");

  // Deliver a valid response slot after a request is taken
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("no response two cycles after a request");

  // Drop the tone period when no tone update is signalled
  a_tone_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.tone_update |-> out_rsp_o.tone_period == 16'd0)
    else $error("tone period without tone update");

endmodule

bind via_timer_register_block via_chk u_via_chk (.*);

// File: verif/tb_via_timer_register_block.sv
// Self-checking testbench for the VIA timer register block.
`timescale 1ns / 1ps

module tb_via_timer_register_block;

  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomRequests = 1150;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  via_pkg::via_req_t  in_req_i;
  logic               out_valid_o;
  logic               out_ready_i;
  via_pkg::via_rsp_t  out_rsp_o;

  // Shadow copy of the register file and key matrix
  logic [7:0] via_regs [via_pkg::NumRegs];
  logic [7:0] key_matrix [via_pkg::KeyRowCountDef];

  via_pkg::via_rsp_t pending_rsp_q [$];
  int unsigned       fault_count;
  bit                in_steady;

  // Directed table: request, whether the response is typed in, and that response
  via_pkg::via_req_t dir_req_q [$];
  bit                dir_typed_q [$];
  via_pkg::via_rsp_t dir_rsp_q [$];

  via_timer_register_block dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Apply one request to the shadow state and return the response it yields
  function automatic via_pkg::via_rsp_t apply_via_request(via_pkg::via_req_t r);
    via_pkg::via_rsp_t rsp;
    logic [15:0]       t1_count;
    logic [15:0]       t2_count;
    logic [3:0]        row;
    logic [7:0]        keys;
    rsp = '0;
    case (r.action)
      via_pkg::ActRead: begin
        case (r.reg_addr)
          via_pkg::RegPortB: begin
            row = via_regs[via_pkg::RegRowSel][3:0];
            keys = via_pkg::KeyRowIdle;
            if (int'(row) < via_pkg::KeyRowCountDef) keys = key_matrix[int'(row)];
            rsp.read_data = keys | (via_regs[via_pkg::RegPortB] & via_pkg::MaskPortHi2);
          end
          via_pkg::RegT1CntLo: begin
            via_regs[via_pkg::RegIfr] &= via_pkg::MaskNotT1;
            rsp.read_data = via_regs[via_pkg::RegT1CntLo];
          end
          via_pkg::RegT2CntLo: begin
            via_regs[via_pkg::RegIfr] &= via_pkg::MaskNotT2;
            rsp.read_data = via_regs[via_pkg::RegT2CntLo];
          end
          default: rsp.read_data = via_regs[r.reg_addr];
        endcase
      end
      via_pkg::ActWrite: begin
        case (r.reg_addr)
          via_pkg::RegT1CntLo, via_pkg::RegT1LatLo: begin
            via_regs[via_pkg::RegT1CntLo] = r.write_data;
            via_regs[via_pkg::RegT1LatLo] = r.write_data;
          end
          via_pkg::RegT1CntHi, via_pkg::RegT1LatHi: begin
            via_regs[via_pkg::RegT1CntHi] = r.write_data;
            via_regs[via_pkg::RegT1LatHi] = r.write_data;
            via_regs[via_pkg::RegIfr] &= via_pkg::MaskNotT1;
            if (via_regs[via_pkg::RegAcr][7:6] == via_pkg::AcrSquare) begin
              rsp.tone_update = 1'b1;
              rsp.tone_period = {via_regs[via_pkg::RegT1LatHi], via_regs[via_pkg::RegT1LatLo]};
            end
          end
          via_pkg::RegT2CntHi: begin
            via_regs[via_pkg::RegT2CntHi] = r.write_data;
            via_regs[via_pkg::RegIfr] &= via_pkg::MaskNotT2;
          end
          via_pkg::RegAcr: begin
            if (r.write_data[7:6] != via_pkg::AcrSquare) begin
              rsp.tone_update = 1'b1;
              rsp.tone_period = '0;
            end
            via_regs[via_pkg::RegAcr] = r.write_data;
          end
          default: via_regs[r.reg_addr] = r.write_data;
        endcase
      end
      via_pkg::ActTick: begin
        t1_count = {via_regs[via_pkg::RegT1CntHi], via_regs[via_pkg::RegT1CntLo]};
        if (t1_count > {8'h00, r.cycle_count}) begin
          t1_count = t1_count - {8'h00, r.cycle_count};
        end else begin
          // Underflow: reload from the latch, toggle PB7 when ACR bit 7 is set
          t1_count = {via_regs[via_pkg::RegT1LatHi], via_regs[via_pkg::RegT1LatLo]};
          t1_count = t1_count - {8'h00, r.cycle_count};
          if ((via_regs[via_pkg::RegAcr] & via_pkg::MaskAcrPb7) != '0) begin
            if (!via_regs[via_pkg::RegPortB][7]) begin
              via_regs[via_pkg::RegPortB] |= via_pkg::MaskPortHi2;
            end else begin
              t2_count = {via_regs[via_pkg::RegT2CntHi], via_regs[via_pkg::RegT2CntLo]};
              via_regs[via_pkg::RegPortB] &= via_pkg::MaskPortLo6;
              if (t2_count != '0) begin
                t2_count = t2_count - 16'd1;
                if (t2_count == '0) via_regs[via_pkg::RegIfr] |= via_pkg::MaskIfrT2;
              end
              via_regs[via_pkg::RegT2CntLo] = t2_count[7:0];
              via_regs[via_pkg::RegT2CntHi] = t2_count[15:8];
            end
          end
          via_regs[via_pkg::RegIfr] |= via_pkg::MaskIfrT1;
        end
        via_regs[via_pkg::RegT1CntLo] = t1_count[7:0];
        via_regs[via_pkg::RegT1CntHi] = t1_count[15:8];
      end
      default: begin
        if (int'(r.key_row) < via_pkg::KeyRowCountDef) begin
          key_matrix[int'(r.key_row)] = r.write_data;
        end
      end
    endcase
    rsp.pb7_level = via_regs[via_pkg::RegPortB][7];
    return rsp;
  endfunction

  // Random request, biased towards timer traffic that reaches underflow
  function automatic via_pkg::via_req_t random_request();
    via_pkg::via_req_t r;
    int unsigned       roll;
    r.action      = via_pkg::ActRead;
    r.reg_addr    = 4'($urandom);
    r.write_data  = 8'($urandom);
    r.cycle_count = 8'($urandom);
    r.key_row     = 4'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      r.action = via_pkg::ActRead;
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: r.reg_addr = via_pkg::RegPortB;
          1: r.reg_addr = via_pkg::RegT1CntLo;
          2: r.reg_addr = via_pkg::RegT2CntLo;
          default: r.reg_addr = via_pkg::RegIfr;
        endcase
      end
    end else if (roll < 55) begin
      r.action = via_pkg::ActWrite;
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0: r.reg_addr = via_pkg::RegRowSel;
          1: r.reg_addr = via_pkg::RegT1CntLo;
          2: r.reg_addr = via_pkg::RegT1CntHi;
          3: r.reg_addr = via_pkg::RegT1LatLo;
          4: r.reg_addr = via_pkg::RegT1LatHi;
          5: r.reg_addr = via_pkg::RegT2CntLo;
          6: r.reg_addr = via_pkg::RegT2CntHi;
          default: r.reg_addr = via_pkg::RegAcr;
        endcase
      end
      // Keep the high bytes mostly clear so the counters wrap often
      if ((r.reg_addr == via_pkg::RegT1CntHi || r.reg_addr == via_pkg::RegT1LatHi ||
           r.reg_addr == via_pkg::RegT2CntHi) && $urandom_range(0, 3) != 0) begin
        r.write_data = '0;
      end
      if (r.reg_addr == via_pkg::RegAcr && $urandom_range(0, 2) != 0) begin
        r.write_data[7] = 1'b1;
      end
    end else if (roll < 90) begin
      r.action = via_pkg::ActTick;
    end else begin
      r.action = via_pkg::ActKeyLoad;
      if ($urandom_range(0, 4) != 0) begin
        r.key_row = 4'($urandom_range(0, via_pkg::KeyRowCountDef - 1));
      end
    end
    return r;
  endfunction

  task automatic add_row(input via_pkg::via_action_e act, input logic [3:0] addr,
                         input logic [7:0] data, input logic [7:0] cycles,
                         input logic [3:0] row, input bit typed, input logic [7:0] rd,
                         input logic upd, input logic [15:0] period, input logic pb7);
    via_pkg::via_req_t r;
    via_pkg::via_rsp_t e;
    r.action      = act;
    r.reg_addr    = addr;
    r.write_data  = data;
    r.cycle_count = cycles;
    r.key_row     = row;
    e.read_data   = rd;
    e.tone_update = upd;
    e.tone_period = period;
    e.pb7_level   = pb7;
    dir_req_q.push_back(r);
    dir_typed_q.push_back(typed);
    dir_rsp_q.push_back(e);
  endtask

  // Present one request, hold it until taken, then record its response
  task automatic send_request(input via_pkg::via_req_t r, input bit typed,
                              input via_pkg::via_rsp_t typed_rsp);
    int unsigned       gap;
    via_pkg::via_rsp_t model_rsp;
    gap = in_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_req_i   = r;
    do @(posedge clk_i); while (!in_ready_o);
    model_rsp = apply_via_request(r);
    pending_rsp_q.push_back(typed ? typed_rsp : model_rsp);
  endtask

  // Stimulus: reset, directed table, then random traffic
  initial begin : run_requests
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    rst_ni      = 1'b0;
    fault_count = 0;
    in_steady   = 1'b0;
    for (int i = 0; i < via_pkg::NumRegs; i++) via_regs[i] = '0;
    for (int i = 0; i < via_pkg::KeyRowCountDef; i++) key_matrix[i] = via_pkg::KeyRowIdle;

    // Reset state, key rows, row select beyond the matrix, tone on
    add_row(via_pkg::ActRead,    via_pkg::RegPortB,   8'h00, 8'h00, 4'd0,
            1'b1, 8'hFF, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActRead,    via_pkg::RegIfr,     8'h00, 8'h00, 4'd0,
            1'b1, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActKeyLoad, via_pkg::RegPortB,   8'h00, 8'h00, 4'd0,
            1'b1, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActKeyLoad, via_pkg::RegPortB,   8'hA5, 8'h00, 4'd8,
            1'b1, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActKeyLoad, via_pkg::RegPortB,   8'h00, 8'h00, 4'd15,
            1'b1, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActWrite,   via_pkg::RegRowSel,  8'h08, 8'h00, 4'd0,
            1'b1, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActRead,    via_pkg::RegPortB,   8'h00, 8'h00, 4'd0,
            1'b1, 8'hA5, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActWrite,   via_pkg::RegRowSel,  8'h0F, 8'h00, 4'd0,
            1'b1, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActRead,    via_pkg::RegPortB,   8'h00, 8'h00, 4'd0,
            1'b1, 8'hFF, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActWrite,   via_pkg::RegRowSel,  8'h00, 8'h00, 4'd0,
            1'b1, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActRead,    via_pkg::RegPortB,   8'h00, 8'h00, 4'd0,
            1'b1, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActWrite,   via_pkg::RegAcr,     8'hC0, 8'h00, 4'd0,
            1'b1, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActWrite,   via_pkg::RegT1LatLo, 8'h03, 8'h00, 4'd0,
            1'b1, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActWrite,   via_pkg::RegT1LatHi, 8'h00, 8'h00, 4'd0,
            1'b1, 8'h00, 1'b1, 16'h0003, 1'b0);
    // Timer 2 preset, underflows with PB7 rise and fall, flag clears, tone off
    add_row(via_pkg::ActWrite,   via_pkg::RegT2CntHi, 8'h00, 8'h00, 4'd0,
            1'b0, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActWrite,   via_pkg::RegT2CntLo, 8'h02, 8'h00, 4'd0,
            1'b0, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActTick,    via_pkg::RegPortB,   8'h00, 8'h03, 4'd0,
            1'b0, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActTick,    via_pkg::RegPortB,   8'h00, 8'h00, 4'd0,
            1'b0, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActTick,    via_pkg::RegPortB,   8'h00, 8'h03, 4'd0,
            1'b0, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActTick,    via_pkg::RegPortB,   8'h00, 8'h00, 4'd0,
            1'b0, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActTick,    via_pkg::RegPortB,   8'h00, 8'hFF, 4'd0,
            1'b0, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActRead,    via_pkg::RegIfr,     8'h00, 8'h00, 4'd0,
            1'b0, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActRead,    via_pkg::RegT1CntLo, 8'h00, 8'h00, 4'd0,
            1'b0, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActRead,    via_pkg::RegT2CntLo, 8'h00, 8'h00, 4'd0,
            1'b0, 8'h00, 1'b0, 16'h0000, 1'b0);
    add_row(via_pkg::ActWrite,   via_pkg::RegAcr,     8'h00, 8'h00, 4'd0,
            1'b0, 8'h00, 1'b0, 16'h0000, 1'b0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < dir_req_q.size(); i++) begin
      send_request(dir_req_q[i], dir_typed_q[i], dir_rsp_q[i]);
    end
    for (int i = 0; i < RandomRequests; i++) begin
      if ($urandom_range(0, 149) == 0) in_steady = !in_steady;
      send_request(random_request(), 1'b0, '0);
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;

    // Drain outstanding responses, then watch for strays
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Response side: random back-pressure and field-by-field checks
  initial begin : drain_responses
    via_pkg::via_rsp_t want;
    int unsigned       stall_left;
    bit                steady;
    stall_left  = 0;
    steady      = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_rsp_q.size() == 0) begin
          $display("%0t: unexpected response rd=%h upd=%b per=%h pb7=%b", $time,
                   out_rsp_o.read_data, out_rsp_o.tone_update, out_rsp_o.tone_period,
                   out_rsp_o.pb7_level);
          fault_count++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (out_rsp_o.read_data !== want.read_data) begin
            $display("%0t: read_data expected %h got %h", $time,
                     want.read_data, out_rsp_o.read_data);
            fault_count++;
          end
          if (out_rsp_o.tone_update !== want.tone_update) begin
            $display("%0t: tone_update expected %b got %b", $time,
                     want.tone_update, out_rsp_o.tone_update);
            fault_count++;
          end
          if (out_rsp_o.tone_period !== want.tone_period) begin
            $display("%0t: tone_period expected %h got %h", $time,
                     want.tone_period, out_rsp_o.tone_period);
            fault_count++;
          end
          if (out_rsp_o.pb7_level !== want.pb7_level) begin
            $display("%0t: pb7_level expected %b got %b", $time,
                     want.pb7_level, out_rsp_o.pb7_level);
            fault_count++;
          end
        end
      end
      @(negedge clk_i);
      if ($urandom_range(0, 199) == 0) steady = !steady;
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = 1'b1;
        if (!steady && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
